/* design/indexed_min_heap_victim_queue_unit_macros.svh */
// ----------------------------------------------------------------------------
// indexed min-heap victim queue assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_VICTIM_QUEUE_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_VICTIM_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define IMHVQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IMHVQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/imhvq_pkg.sv */
// ----------------------------------------------------------------------------
// imhvq_pkg
// field widths and opcodes of the victim queue
// ----------------------------------------------------------------------------
package imhvq_pkg;

    localparam int OP_W  = 2;
    localparam int ID_W  = 8;
    localparam int KEY_W = 16;
    localparam int OCC_W = 9;

    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

endpackage

/* design/imhvq_order_cmp.sv */
// ----------------------------------------------------------------------------
// imhvq_order_cmp
// heap order compare: lower key first, lower unit id on equal keys
// ----------------------------------------------------------------------------
module imhvq_order_cmp #(
    parameter int UNIT_BITS = 8,
    parameter int KEY_BITS  = 16
) (
    input  logic [UNIT_BITS-1:0] a_id,
    input  logic [KEY_BITS-1:0]  a_key,
    input  logic [UNIT_BITS-1:0] b_id,
    input  logic [KEY_BITS-1:0]  b_key,
    output logic                 a_first
);

    logic key_lt;
    logic key_eq;
    logic id_lt;

    assign key_lt  = a_key < b_key;
    assign key_eq  = a_key == b_key;
    assign id_lt   = a_id < b_id;
    assign a_first = key_lt || (key_eq && id_lt);

endmodule

/* design/indexed_min_heap_victim_queue_unit.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_victim_queue_unit
// garbage-collection victim queue: indexed binary min-heap of erase units
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  req      req_valid/req_stall opcode, entry_id, key_value
//  rsp      rsp_valid/rsp_stall has_minimum, minimum_id, minimum_key, occupancy
//
//  one item at a time: req_stall is high from accept until the result loads
//  query reads the root and its key (not when empty); update or remove sifts
//  up by level (parent, key, compare) or down (children, keys, compare, move)
//  until in order or at root or leaf; each memory has a single read port
//  after reset a pass over all MAX_UNITS entries zeroes slot and key stores
//  a full output register holds the sequencer in its final state
// ----------------------------------------------------------------------------
module indexed_min_heap_victim_queue_unit #(
    parameter int MAX_UNITS = 256,
    parameter int KEY_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [imhvq_pkg::OP_W-1:0]  opcode,
    input  logic [imhvq_pkg::ID_W-1:0]  entry_id,
    input  logic [imhvq_pkg::KEY_W-1:0] key_value,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic                        has_minimum,
    output logic [imhvq_pkg::ID_W-1:0]  minimum_id,
    output logic [imhvq_pkg::KEY_W-1:0] minimum_key,
    output logic [imhvq_pkg::OCC_W-1:0] occupancy
);

    import imhvq_pkg::*;

    localparam int UNIT_BITS  = $clog2(MAX_UNITS);
    localparam int CNT_BITS   = $clog2(MAX_UNITS + 1);
    localparam int CHILD_BITS = CNT_BITS + 1;

    typedef enum logic [17:0] {
        S_CLR    = 18'h00001,
        S_IDLE   = 18'h00002,
        S_UPD_RD = 18'h00004,
        S_REM_RD = 18'h00008,
        S_REM_L  = 18'h00010,
        S_REM_K  = 18'h00020,
        S_UP     = 18'h00040,
        S_UP_K   = 18'h00080,
        S_UP_C   = 18'h00100,
        S_DN     = 18'h00200,
        S_DN_L   = 18'h00400,
        S_DN_LK  = 18'h00800,
        S_DN_RK  = 18'h01000,
        S_DN_MV  = 18'h02000,
        S_FIN    = 18'h04000,
        S_ROOT   = 18'h08000,
        S_ROOT_K = 18'h10000,
        S_OUT    = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic [UNIT_BITS-1:0] clr_reg, clr_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [UNIT_BITS-1:0] x_reg, x_next;
    logic [KEY_BITS-1:0]  xk_reg, xk_next;
    logic [UNIT_BITS-1:0] pos_reg, pos_next;
    logic                 first_reg, first_next;
    logic [UNIT_BITS-1:0] lu_reg, lu_next;
    logic [UNIT_BITS-1:0] bu_reg, bu_next;
    logic [KEY_BITS-1:0]  bk_reg, bk_next;
    logic [UNIT_BITS-1:0] bpos_reg, bpos_next;
    logic                 bx_reg, bx_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 has_min_reg, has_min_next;
    logic [ID_W-1:0]      min_id_reg, min_id_next;
    logic [KEY_W-1:0]     min_key_reg, min_key_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;

    logic [UNIT_BITS-1:0] heap_mem [MAX_UNITS];
    logic [CNT_BITS-1:0]  slot_mem [MAX_UNITS];
    logic [KEY_BITS-1:0]  key_mem  [MAX_UNITS];

    logic [UNIT_BITS-1:0] heap_rd_reg;
    logic [CNT_BITS-1:0]  slot_rd_reg;
    logic [KEY_BITS-1:0]  key_rd_reg;

    logic                 heap_we, heap_re, slot_we, slot_re, key_we, key_re;
    logic [UNIT_BITS-1:0] heap_wa, heap_ra, slot_wa, slot_ra, key_wa, key_ra;
    logic [UNIT_BITS-1:0] heap_wd;
    logic [CNT_BITS-1:0]  slot_wd;
    logic [KEY_BITS-1:0]  key_wd;

    logic [UNIT_BITS-1:0] cmp_a_id, cmp_b_id;
    logic [KEY_BITS-1:0]  cmp_a_key, cmp_b_key;
    logic                 cmp_first;

    logic [31:0]           id_ext, key_ext, root_ext, rkey_ext, cnt_ext;
    logic                  in_range;
    logic [UNIT_BITS-1:0]  req_id;
    logic [KEY_BITS-1:0]   req_key;
    logic                  req_take;
    logic                  rsp_take;
    logic [UNIT_BITS-1:0]  pos_m1;
    logic [UNIT_BITS-1:0]  parent_pos;
    logic [CHILD_BITS-1:0] lc, rc;
    logic                  l_ok, r_ok;
    logic [CNT_BITS-1:0]   pos_slot;
    logic [CNT_BITS-1:0]   where_m1;
    logic [CNT_BITS-1:0]   cnt_m1;

    assign id_ext     = 32'(entry_id);
    assign key_ext    = 32'(key_value);
    assign in_range   = id_ext < 32'(MAX_UNITS);
    assign req_id     = id_ext[UNIT_BITS-1:0];
    assign req_key    = key_ext[KEY_BITS-1:0];
    assign req_take   = req_valid && (state_reg == S_IDLE);
    assign rsp_take   = rsp_valid_reg && !rsp_stall;
    assign pos_m1     = pos_reg - UNIT_BITS'(1);
    assign parent_pos = pos_m1 >> 1;
    assign lc         = (CHILD_BITS'(pos_reg) << 1) + CHILD_BITS'(1);
    assign rc         = lc + CHILD_BITS'(1);
    assign l_ok       = lc < CHILD_BITS'(cnt_reg);
    assign r_ok       = rc < CHILD_BITS'(cnt_reg);
    assign pos_slot   = CNT_BITS'(pos_reg) + CNT_BITS'(1);
    assign where_m1   = slot_rd_reg - CNT_BITS'(1);
    assign cnt_m1     = cnt_reg - CNT_BITS'(1);
    assign root_ext   = 32'(heap_rd_reg);
    assign rkey_ext   = 32'(key_rd_reg);
    assign cnt_ext    = 32'(cnt_reg);

    imhvq_order_cmp #(
        .UNIT_BITS (UNIT_BITS),
        .KEY_BITS  (KEY_BITS)
    ) u_cmp (
        .a_id    (cmp_a_id),
        .a_key   (cmp_a_key),
        .b_id    (cmp_b_id),
        .b_key   (cmp_b_key),
        .a_first (cmp_first)
    );

    always_comb
    begin
        cmp_a_id  = x_reg;
        cmp_a_key = xk_reg;
        cmp_b_id  = heap_rd_reg;
        cmp_b_key = key_rd_reg;
        if (state_reg == S_DN_LK)
        begin
            cmp_a_id  = lu_reg;
            cmp_a_key = key_rd_reg;
            cmp_b_id  = x_reg;
            cmp_b_key = xk_reg;
        end
        else if (state_reg == S_DN_RK)
        begin
            cmp_a_id  = heap_rd_reg;
            cmp_a_key = key_rd_reg;
            cmp_b_id  = bu_reg;
            cmp_b_key = bk_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        xk_next        = xk_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        lu_next        = lu_reg;
        bu_next        = bu_reg;
        bk_next        = bk_reg;
        bpos_next      = bpos_reg;
        bx_next        = bx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_take;
        has_min_next   = has_min_reg;
        min_id_next    = min_id_reg;
        min_key_next   = min_key_reg;
        occ_next       = occ_reg;

        heap_we = 1'b0;
        heap_wa = '0;
        heap_wd = '0;
        heap_re = 1'b0;
        heap_ra = '0;
        slot_we = 1'b0;
        slot_wa = '0;
        slot_wd = '0;
        slot_re = 1'b0;
        slot_ra = '0;
        key_we  = 1'b0;
        key_wa  = '0;
        key_wd  = '0;
        key_re  = 1'b0;
        key_ra  = '0;

        unique case (state_reg)
            S_CLR:
            begin
                slot_we  = 1'b1;
                slot_wa  = clr_reg;
                key_we   = 1'b1;
                key_wa   = clr_reg;
                clr_next = clr_reg + UNIT_BITS'(1);
                if (clr_reg == UNIT_BITS'(MAX_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_take)
                begin
                    x_next     = req_id;
                    xk_next    = req_key;
                    state_next = S_ROOT;
                    if (in_range)
                    begin
                        unique case (opcode)
                            OP_UPDATE:
                            begin
                                slot_re    = 1'b1;
                                slot_ra    = req_id;
                                key_re     = 1'b1;
                                key_ra     = req_id;
                                state_next = S_UPD_RD;
                            end
                            OP_REMOVE:
                            begin
                                slot_re    = 1'b1;
                                slot_ra    = req_id;
                                state_next = S_REM_RD;
                            end
                            default:
                            begin
                                state_next = S_ROOT;
                            end
                        endcase
                    end
                end
            end
            S_UPD_RD:
            begin
                key_we     = 1'b1;
                key_wa     = x_reg;
                key_wd     = xk_reg;
                first_next = 1'b0;
                if (slot_rd_reg == '0)
                begin
                    if (cnt_reg >= CNT_BITS'(MAX_UNITS))
                    begin
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        pos_next   = cnt_reg[UNIT_BITS-1:0];
                        cnt_next   = cnt_reg + CNT_BITS'(1);
                        state_next = S_UP;
                    end
                end
                else
                begin
                    pos_next = where_m1[UNIT_BITS-1:0];
                    if (xk_reg < key_rd_reg)
                    begin
                        state_next = S_UP;
                    end
                    else if (xk_reg > key_rd_reg)
                    begin
                        state_next = S_DN;
                    end
                    else
                    begin
                        state_next = S_ROOT;
                    end
                end
            end
            S_REM_RD:
            begin
                if (slot_rd_reg == '0 || cnt_reg == '0)
                begin
                    state_next = S_ROOT;
                end
                else
                begin
                    slot_we  = 1'b1;
                    slot_wa  = x_reg;
                    cnt_next = cnt_m1;
                    pos_next = where_m1[UNIT_BITS-1:0];
                    if (where_m1 >= cnt_m1)
                    begin
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        heap_re    = 1'b1;
                        heap_ra    = cnt_m1[UNIT_BITS-1:0];
                        state_next = S_REM_L;
                    end
                end
            end
            S_REM_L:
            begin
                x_next     = heap_rd_reg;
                key_re     = 1'b1;
                key_ra     = heap_rd_reg;
                state_next = S_REM_K;
            end
            S_REM_K:
            begin
                xk_next    = key_rd_reg;
                first_next = 1'b1;
                state_next = S_UP;
            end
            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    state_next = first_reg ? S_DN : S_FIN;
                end
                else
                begin
                    heap_re    = 1'b1;
                    heap_ra    = parent_pos;
                    state_next = S_UP_K;
                end
            end
            S_UP_K:
            begin
                key_re     = 1'b1;
                key_ra     = heap_rd_reg;
                state_next = S_UP_C;
            end
            S_UP_C:
            begin
                if (cmp_first)
                begin
                    heap_we    = 1'b1;
                    heap_wa    = pos_reg;
                    heap_wd    = heap_rd_reg;
                    slot_we    = 1'b1;
                    slot_wa    = heap_rd_reg;
                    slot_wd    = pos_slot;
                    pos_next   = parent_pos;
                    first_next = 1'b0;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = first_reg ? S_DN : S_FIN;
                end
            end
            S_DN:
            begin
                first_next = 1'b0;
                if (l_ok)
                begin
                    heap_re    = 1'b1;
                    heap_ra    = lc[UNIT_BITS-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_L:
            begin
                lu_next = heap_rd_reg;
                key_re  = 1'b1;
                key_ra  = heap_rd_reg;
                if (r_ok)
                begin
                    heap_re = 1'b1;
                    heap_ra = rc[UNIT_BITS-1:0];
                end
                state_next = S_DN_LK;
            end
            S_DN_LK:
            begin
                if (cmp_first)
                begin
                    bx_next   = 1'b0;
                    bu_next   = lu_reg;
                    bk_next   = key_rd_reg;
                    bpos_next = lc[UNIT_BITS-1:0];
                end
                else
                begin
                    bx_next = 1'b1;
                    bu_next = x_reg;
                    bk_next = xk_reg;
                end
                if (r_ok)
                begin
                    key_re     = 1'b1;
                    key_ra     = heap_rd_reg;
                    state_next = S_DN_RK;
                end
                else
                begin
                    state_next = S_DN_MV;
                end
            end
            S_DN_RK:
            begin
                if (cmp_first)
                begin
                    bx_next   = 1'b0;
                    bu_next   = heap_rd_reg;
                    bk_next   = key_rd_reg;
                    bpos_next = rc[UNIT_BITS-1:0];
                end
                state_next = S_DN_MV;
            end
            S_DN_MV:
            begin
                if (bx_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_wa    = pos_reg;
                    heap_wd    = bu_reg;
                    slot_we    = 1'b1;
                    slot_wa    = bu_reg;
                    slot_wd    = pos_slot;
                    pos_next   = bpos_reg;
                    state_next = S_DN;
                end
            end
            S_FIN:
            begin
                heap_we    = 1'b1;
                heap_wa    = pos_reg;
                heap_wd    = x_reg;
                slot_we    = 1'b1;
                slot_wa    = x_reg;
                slot_wd    = pos_slot;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    heap_re    = 1'b1;
                    heap_ra    = '0;
                    state_next = S_ROOT_K;
                end
            end
            S_ROOT_K:
            begin
                key_re     = 1'b1;
                key_ra     = heap_rd_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    has_min_next   = cnt_reg != '0;
                    min_id_next    = (cnt_reg != '0) ? root_ext[ID_W-1:0] : '0;
                    min_key_next   = (cnt_reg != '0) ? rkey_ext[KEY_W-1:0] : '0;
                    occ_next       = cnt_ext[OCC_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        xk_reg      <= xk_next;
        pos_reg     <= pos_next;
        lu_reg      <= lu_next;
        bu_reg      <= bu_next;
        bk_reg      <= bk_next;
        bpos_reg    <= bpos_next;
        bx_reg      <= bx_next;
        has_min_reg <= has_min_next;
        min_id_reg  <= min_id_next;
        min_key_reg <= min_key_next;
        occ_reg     <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        if (heap_re)
        begin
            heap_rd_reg <= heap_mem[heap_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (key_re)
        begin
            key_rd_reg <= key_mem[key_ra];
        end
    end

    assign req_stall   = state_reg != S_IDLE;
    assign rsp_valid   = rsp_valid_reg;
    assign has_minimum = has_min_reg;
    assign minimum_id  = min_id_reg;
    assign minimum_key = min_key_reg;
    assign occupancy   = occ_reg;

endmodule

/* design/imhvq_checker.sv */
// ----------------------------------------------------------------------------
// imhvq_checker
// port-level checks of the victim queue, bound to the top level
// ----------------------------------------------------------------------------
`include "indexed_min_heap_victim_queue_unit_macros.svh"

module imhvq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_stall,
    input logic                        rsp_valid,
    input logic                        rsp_stall,
    input logic                        has_minimum,
    input logic [imhvq_pkg::ID_W-1:0]  minimum_id,
    input logic [imhvq_pkg::KEY_W-1:0] minimum_key,
    input logic [imhvq_pkg::OCC_W-1:0] occupancy
);

    `IMHVQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "not busy after item accept")
    `IMHVQ_ASSERT_NOW(a_empty_zero, rsp_valid && !has_minimum, minimum_id == 0 && minimum_key == 0 && occupancy == 0, "empty result not zero")
    `IMHVQ_ASSERT_NEXT(a_no_extra_result, rsp_valid && !rsp_stall && !req_stall, !rsp_valid, "result without item")
    `IMHVQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(minimum_id) && $stable(minimum_key) && $stable(occupancy) && $stable(has_minimum), "stalled result changed")

endmodule

bind indexed_min_heap_victim_queue_unit imhvq_checker u_imhvq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .has_minimum (has_minimum),
    .minimum_id  (minimum_id),
    .minimum_key (minimum_key),
    .occupancy   (occupancy)
);
